### src/rmth_pkg.sv
// Package for the running median block: data widths, default capacity and
// the command that the top level broadcasts to every cell of a chain.
// No dependencies.
package rmth_pkg;

  localparam int SAMPLE_W     = 32;
  localparam int MEDIAN_W     = 33;
  localparam int CAPACITY_DEF = 1024;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    OP_NOP     = 2'd0,
    OP_PUSH    = 2'd1,
    OP_REPLACE = 2'd2
  } chain_op_t;

  typedef struct packed {
    chain_op_t op;
    sample_t   value;
  } chain_cmd_t;

endpackage

### src/rmth_in_if.sv
// Input channel of the running median block: one sample per beat.
// Depends on rmth_pkg.
interface rmth_in_if
  import rmth_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

### src/rmth_out_if.sv
// Output channel of the running median block: one result per beat.
// Depends on rmth_pkg.
interface rmth_out_if
  import rmth_pkg::*;
#(
  parameter int COUNT_W = 11
) ();
  logic                       valid;
  logic                       ready;
  logic signed [MEDIAN_W-1:0] median_doubled;
  logic [COUNT_W-1:0]         stored_count;
  logic                       rejected_full;

  modport source (output valid, output median_doubled, output stored_count,
                  output rejected_full, input ready);
  modport sink (input valid, input median_doubled, input stored_count,
                input rejected_full, output ready);
endinterface

### src/rmth_cell.sv
// One cell of a sorted chain: holds one value and an occupied flag.
// Depends on rmth_pkg; instantiated by rmth_chain.
module rmth_cell
  import rmth_pkg::*;
#(
  parameter bit IS_MAX = 1'b1
) (
  input  logic       clk,
  input  logic       rst,
  input  chain_cmd_t cmd,
  input  sample_t    left_w_value,
  input  logic       left_w_used,
  input  logic       left_keep,
  input  sample_t    right_value,
  input  logic       right_used,
  output sample_t    value,
  output logic       used,
  output sample_t    w_value,
  output logic       w_used,
  output logic       keep
);

  logic    ranks_first;
  sample_t value_next;
  logic    used_next;

  // A replace first shifts the chain one place toward the top, then inserts.
  assign w_value = (cmd.op == OP_REPLACE) ? right_value : value;
  assign w_used  = (cmd.op == OP_REPLACE) ? right_used : used;

  assign ranks_first = IS_MAX ? (cmd.value > w_value) : (cmd.value < w_value);
  assign keep        = w_used && !ranks_first;

  always_comb begin
    value_next = value;
    used_next  = used;
    case (cmd.op)
      OP_PUSH, OP_REPLACE: begin
        if (keep) begin
          value_next = w_value;
          used_next  = w_used;
        end else if (left_keep) begin
          value_next = cmd.value;
          used_next  = 1'b1;
        end else begin
          value_next = left_w_value;
          used_next  = left_w_used;
        end
      end
      default: begin
        value_next = value;
        used_next  = used;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else begin
      used <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

### src/rmth_chain.sv
// A sorted chain of cells acting as a priority queue with its top in cell 0.
// Depends on rmth_pkg and rmth_cell.
module rmth_chain
  import rmth_pkg::*;
#(
  parameter int DEPTH  = CAPACITY_DEF / 2,
  parameter bit IS_MAX = 1'b1
) (
  input  logic       clk,
  input  logic       rst,
  input  chain_cmd_t cmd,
  output sample_t    top_value
);

  sample_t cell_value [DEPTH];
  logic    cell_used  [DEPTH];
  sample_t cell_w_value [DEPTH];
  logic    cell_w_used  [DEPTH];
  logic    cell_keep    [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sample_t l_w_value;
    logic    l_w_used;
    logic    l_keep;
    sample_t r_value;
    logic    r_used;

    if (i == 0) begin : g_head
      assign l_w_value = '0;
      assign l_w_used  = 1'b0;
      assign l_keep    = 1'b1;
    end else begin : g_body
      assign l_w_value = cell_w_value[i-1];
      assign l_w_used  = cell_w_used[i-1];
      assign l_keep    = cell_keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_value = '0;
      assign r_used  = 1'b0;
    end else begin : g_next
      assign r_value = cell_value[i+1];
      assign r_used  = cell_used[i+1];
    end

    rmth_cell #(
      .IS_MAX(IS_MAX)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_w_value(l_w_value),
      .left_w_used (l_w_used),
      .left_keep   (l_keep),
      .right_value (r_value),
      .right_used  (r_used),
      .value       (cell_value[i]),
      .used        (cell_used[i]),
      .w_value     (cell_w_value[i]),
      .w_used      (cell_w_used[i]),
      .keep        (cell_keep[i])
    );
  end

  assign top_value = cell_value[0];

endmodule

### src/running_median_two_heaps.sv
// Top level of the running median block: control, middle register and the
// two sorted chains. Depends on rmth_pkg, rmth_in_if, rmth_out_if, rmth_chain.
//
// Usage: each beat on sample_in carries one signed 32-bit sample. For every
// sample one beat leaves on result_out with twice the running median, the
// number of samples held and a flag that is set when the store was already
// full and the sample was dropped (the median and count then repeat).
// Each item passes through these steps in order: the sample is captured,
// both chains of cells shift and insert in parallel, and the result is formed
// from the new tops and loaded into the output register. A new sample is
// not accepted before the previous one has reached the output register.
// The next sample is accepted while a result still waits in the output
// register; if the receiver stalls, the following result is held
// internally and sample_in stays not ready until the output register frees.
// Reset empties both chains, clears the count and the middle register and
// drops any pending result. The block is ready in the first cycle after
// reset.
module running_median_two_heaps
  import rmth_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic          clk,
  input logic          rst,
  rmth_in_if.sink      sample_in,
  rmth_out_if.source   result_out
);

  localparam int DEPTH   = CAPACITY / 2;
  localparam int SIZE_W  = $clog2(DEPTH + 1);
  localparam int COUNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_APPLY  = 3'b010,
    ST_RESULT = 3'b100
  } state_t;

  state_t              state;
  state_t              state_next;
  sample_t             sample;
  sample_t             middle;
  sample_t             middle_next;
  logic [SIZE_W-1:0]   lower_size;
  logic [SIZE_W-1:0]   lower_size_next;
  logic [SIZE_W-1:0]   upper_size;
  logic [SIZE_W-1:0]   upper_size_next;
  logic [COUNT_W-1:0]  total_count;
  logic                rejected;
  chain_cmd_t          lower_cmd;
  chain_cmd_t          upper_cmd;
  sample_t             lower_top;
  sample_t             upper_top;
  logic                out_valid;
  logic                out_load;
  logic signed [MEDIAN_W-1:0] median_calc;

  rmth_chain #(
    .DEPTH (DEPTH),
    .IS_MAX(1'b1)
  ) u_lower (
    .clk      (clk),
    .rst      (rst),
    .cmd      (lower_cmd),
    .top_value(lower_top)
  );

  rmth_chain #(
    .DEPTH (DEPTH),
    .IS_MAX(1'b0)
  ) u_upper (
    .clk      (clk),
    .rst      (rst),
    .cmd      (upper_cmd),
    .top_value(upper_top)
  );

  assign sample_in.ready = (state == ST_IDLE);
  assign out_load = (state == ST_RESULT) && (!out_valid || result_out.ready);

  always_comb begin
    lower_cmd       = '{op: OP_NOP, value: sample};
    upper_cmd       = '{op: OP_NOP, value: sample};
    middle_next     = middle;
    lower_size_next = lower_size;
    upper_size_next = upper_size;
    if (state == ST_APPLY && total_count < COUNT_W'(CAPACITY)) begin
      if (total_count == '0) begin
        middle_next = sample;
      end else if (sample <= middle) begin
        if (lower_size == upper_size) begin
          lower_cmd       = '{op: OP_PUSH, value: sample};
          lower_size_next = lower_size + 1'b1;
        end else begin
          upper_cmd       = '{op: OP_PUSH, value: middle};
          upper_size_next = upper_size + 1'b1;
          if (lower_size == '0 || sample >= lower_top) begin
            middle_next = sample;
          end else begin
            middle_next = lower_top;
            lower_cmd   = '{op: OP_REPLACE, value: sample};
          end
        end
      end else begin
        if (lower_size > upper_size) begin
          upper_cmd       = '{op: OP_PUSH, value: sample};
          upper_size_next = upper_size + 1'b1;
        end else begin
          lower_cmd       = '{op: OP_PUSH, value: middle};
          lower_size_next = lower_size + 1'b1;
          if (upper_size == '0 || sample <= upper_top) begin
            middle_next = sample;
          end else begin
            middle_next = upper_top;
            upper_cmd   = '{op: OP_REPLACE, value: sample};
          end
        end
      end
    end
  end

  always_comb begin
    if (total_count == '0) begin
      median_calc = '0;
    end else if (total_count[0] || lower_size == '0) begin
      median_calc = {middle, 1'b0};
    end else begin
      median_calc = $signed({middle[SAMPLE_W-1], middle})
                  + $signed({lower_top[SAMPLE_W-1], lower_top});
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_in.valid) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      middle      <= '0;
      lower_size  <= '0;
      upper_size  <= '0;
      total_count <= '0;
      rejected    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state      <= state_next;
      middle     <= middle_next;
      lower_size <= lower_size_next;
      upper_size <= upper_size_next;
      if (state == ST_APPLY) begin
        if (total_count < COUNT_W'(CAPACITY)) begin
          total_count <= total_count + 1'b1;
          rejected    <= 1'b0;
        end else begin
          rejected <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_in.valid && sample_in.ready) begin
      sample <= sample_in.sample_value;
    end
    if (out_load) begin
      result_out.median_doubled <= median_calc;
      result_out.stored_count   <= total_count;
      result_out.rejected_full  <= rejected;
    end
  end

  assign result_out.valid = out_valid;

endmodule
